// File: src/qcr_pkg.sv
package qcr_pkg;

  localparam int QW         = 17;   // unsigned quality Q1.16, 0 .. 1.0
  localparam int CW         = 8;    // one color channel
  localparam int RGBW       = 24;
  localparam int NUM_W      = 25;   // 255 * 65536 + 32768 fits
  localparam int DIV_STEPS  = 8;    // quotient never exceeds 255
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 41;

  localparam logic [QW-1:0]   QONE      = 17'h10000;
  localparam logic [RGBW-1:0] OOR_RESET = 24'h9F00FF;
  localparam logic [RGBW-1:0] BLACK     = 24'h000000;
  localparam logic [RGBW-1:0] WHITE     = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 3'd0,
    REG_OOR_COLOR   = 3'd1,
    REG_POINT_BASE  = 3'd2
  } reg_idx_t;

  // Data that rides beside the interpolation path.
  typedef struct packed {
    logic            oor;
    logic            direct;
    logic [RGBW-1:0] rgb;
  } side_t;

endpackage

// File: src/quality_color_ramp_unit.sv
// Channel   | Direction | Signals                          | Handshake
// ----------+-----------+----------------------------------+--------------------------
// input     | in        | quality                          | start high, busy low
// result    | out       | red, green, blue, out_of_range   | done high for one cycle
// config    | in        | cfg_index, cfg_data              | cfg_we high
//
// An item accepted at a clock edge passes through stages 0 to 4, the eight-step
// restoring divider and the output register before done rises, and a new item may
// be started in every cycle. Reset clears all valid bits and the configuration
// registers. The receiver cannot stall, so the pipeline never holds; busy is high
// only during reset.
module quality_color_ramp_unit #(
  parameter int MAX_POINTS = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [qcr_pkg::QW:0]    quality,
  input  logic                           cfg_we,
  input  logic [qcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qcr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output logic [qcr_pkg::CW-1:0]         red,
  output logic [qcr_pkg::CW-1:0]         green,
  output logic [qcr_pkg::CW-1:0]         blue,
  output logic                           out_of_range
);
  import qcr_pkg::*;

  // Configuration registers.
  logic [CFG_IDX_W-1:0]  point_count;
  logic [RGBW-1:0]       oor_color;
  logic [CFG_DATA_W-1:0] pts [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      oor_color   <= OOR_RESET;
      for (int k = 0; k < MAX_POINTS; k++) begin
        pts[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_POINT_COUNT) begin
        point_count <= cfg_data[CFG_IDX_W-1:0];
      end
      if (cfg_index == REG_OOR_COLOR) begin
        oor_color <= cfg_data[RGBW-1:0];
      end
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_POINT_BASE) + k)) begin
          pts[k] <= cfg_data;
        end
      end
    end
  end

  // A slot takes part when it lies below the count; a count above the slot
  // total therefore acts as the slot total.
  logic [MAX_POINTS-1:0] active;
  logic [QW-1:0]         pq  [MAX_POINTS];
  logic [RGBW-1:0]       pc  [MAX_POINTS];
  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      active[k] = 32'(point_count) > k;
      pq[k]     = pts[k][CFG_DATA_W-1:RGBW];
      pc[k]     = pts[k][RGBW-1:0];
    end
  end

  assign busy = rst;

  // Stage 0: register the accepted item.
  logic                   s0_v;
  logic signed [QW:0]     s0_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= start && !busy;
    end
    s0_q <= quality;
  end

  // Stage 1: range check, exact match and the bracketing breakpoints.
  logic [QW-1:0]   q0;
  logic            oor_c, found_c;
  logic [RGBW-1:0] found_rgb;
  logic [QW-1:0]   qa_c, qb_c;
  always_comb begin
    q0        = s0_q[QW-1:0];
    oor_c     = s0_q[QW] || (q0 > QONE);
    found_c   = 1'b0;
    found_rgb = BLACK;
    qa_c      = '0;
    qb_c      = QONE;
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (active[k] && pq[k] == q0) begin
        found_c   = 1'b1;
        found_rgb = pc[k];
      end
      if (active[k] && qa_c < pq[k] && pq[k] < q0) begin
        qa_c = pq[k];
      end
      if (active[k] && qb_c > pq[k] && pq[k] > q0) begin
        qb_c = pq[k];
      end
    end
  end

  logic          s1_v;
  side_t         s1_side;
  logic [QW-1:0] s1_q, s1_qa, s1_qb;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= s0_v;
    end
    s1_side.oor    <= oor_c;
    s1_side.direct <= oor_c || found_c || q0 == '0 || q0 == QONE;
    if (oor_c) begin
      s1_side.rgb <= oor_color;
    end else if (found_c) begin
      s1_side.rgb <= found_rgb;
    end else if (q0 == '0) begin
      s1_side.rgb <= BLACK;
    end else begin
      s1_side.rgb <= WHITE;
    end
    s1_q  <= q0;
    s1_qa <= qa_c;
    s1_qb <= qb_c;
  end

  // Stage 2: colors of both ends and the distances.
  logic [RGBW-1:0] c0_c, c1_c;
  always_comb begin
    c0_c = (s1_qa == '0) ? BLACK : WHITE;
    c1_c = (s1_qb == '0) ? BLACK : WHITE;
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (active[k] && pq[k] == s1_qa) begin
        c0_c = pc[k];
      end
      if (active[k] && pq[k] == s1_qb) begin
        c1_c = pc[k];
      end
    end
  end

  logic            s2_v;
  side_t           s2_side;
  logic [RGBW-1:0] s2_c0, s2_c1;
  logic [QW-1:0]   s2_den, s2_w0, s2_w1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_side <= s1_side;
    s2_c0   <= c0_c;
    s2_c1   <= c1_c;
    s2_den  <= s1_qb - s1_qa;
    s2_w0   <= s1_qb - s1_q;
    s2_w1   <= s1_q - s1_qa;
  end

  // Stage 3: weighted products, one pair per channel. Both factors are widened
  // first so the product keeps all of its bits.
  logic             s3_v;
  side_t            s3_side;
  logic [QW-1:0]    s3_den;
  logic [NUM_W-1:0] s3_p0 [3];
  logic [NUM_W-1:0] s3_p1 [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_side <= s2_side;
    s3_den  <= s2_den;
    for (int ch = 0; ch < 3; ch++) begin
      s3_p0[ch] <= NUM_W'(s2_c0[ch*CW +: CW]) * NUM_W'(s2_w0);
      s3_p1[ch] <= NUM_W'(s2_c1[ch*CW +: CW]) * NUM_W'(s2_w1);
    end
  end

  // Stage 4: numerator with the half-divisor for round to nearest.
  logic             s4_v;
  side_t            s4_side;
  logic [QW-1:0]    s4_den;
  logic [NUM_W-1:0] s4_num [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= s3_v;
    end
    s4_side <= s3_side;
    s4_den  <= s3_den;
    for (int ch = 0; ch < 3; ch++) begin
      s4_num[ch] <= s3_p0[ch] + s3_p1[ch] + NUM_W'(s3_den >> 1);
    end
  end

  // Three dividers run in lockstep; the side data follows on a shift line.
  logic [2:0]    dv_valid;
  logic [CW-1:0] dv_quot [3];
  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    qcr_divider u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (s4_v),
      .num       (s4_num[ch]),
      .den       (s4_den),
      .out_valid (dv_valid[ch]),
      .quot      (dv_quot[ch])
    );
  end

  side_t side_line [DIV_STEPS];
  always_ff @(posedge clk) begin
    side_line[0] <= s4_side;
    for (int s = 1; s < DIV_STEPS; s++) begin
      side_line[s] <= side_line[s-1];
    end
  end

  // Output register: direct colors bypass the interpolated quotient.
  side_t side_out;
  assign side_out = side_line[DIV_STEPS-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid[0];
    end
    out_of_range <= side_out.oor;
    if (side_out.direct) begin
      red   <= side_out.rgb[2*CW +: CW];
      green <= side_out.rgb[CW +: CW];
      blue  <= side_out.rgb[0 +: CW];
    end else begin
      red   <= dv_quot[2];
      green <= dv_quot[1];
      blue  <= dv_quot[0];
    end
  end

  // An interpolated item must sit strictly between its two breakpoints.
  a_bracket: assert property (@(posedge clk) disable iff (rst)
    s1_v && !s1_side.direct |-> s1_qa < s1_q && s1_q < s1_qb)
    else $error("interpolation bracket does not enclose the quality");

  // The three channel dividers must stay in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    dv_valid[0] == dv_valid[1] && dv_valid[0] == dv_valid[2])
    else $error("channel dividers out of step");

  // An item in stage 1 reaches the numerator stage through the stage 2 and stage 3 registers.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s1_v |=> ##2 s4_v)
    else $error("item lost in the front pipeline");

  // Out-of-range items never use the interpolated path.
  a_oor_direct: assert property (@(posedge clk) disable iff (rst)
    s1_v && s1_side.oor |-> s1_side.direct)
    else $error("out-of-range item routed to interpolation");

endmodule

// File: src/qcr_divider.sv
module qcr_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [qcr_pkg::NUM_W-1:0] num,
  input  logic [qcr_pkg::QW-1:0]    den,
  output logic                      out_valid,
  output logic [qcr_pkg::CW-1:0]    quot
);
  import qcr_pkg::*;

  // One restoring step per stage, most significant quotient bit first.
  logic [NUM_W-1:0] rem   [DIV_STEPS+1];
  logic [QW-1:0]    dens  [DIV_STEPS+1];
  logic [CW-1:0]    qacc  [DIV_STEPS+1];
  logic             vld   [DIV_STEPS+1];

  assign rem[0]  = num;
  assign dens[0] = den;
  assign qacc[0] = '0;
  assign vld[0]  = in_valid;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int B = DIV_STEPS - 1 - s;
    logic [NUM_W-1:0] trial;
    logic             fits;
    assign trial = NUM_W'(dens[s]) << B;
    assign fits  = rem[s] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1]  <= fits ? rem[s] - trial : rem[s];
      dens[s+1] <= dens[s];
      qacc[s+1] <= qacc[s] | (CW'(fits) << B);
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign quot      = qacc[DIV_STEPS];

endmodule

// File: verif/quality_color_ramp_unit_tb.sv
`timescale 1ns / 100ps

module quality_color_ramp_unit_tb;
  import qcr_pkg::*;

  localparam int LATENCY = 14;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
    logic          oor;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [QW:0] quality = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic [CW-1:0] red, green, blue;
  logic out_of_range;

  quality_color_ramp_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .quality(quality),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .red(red), .green(green), .blue(blue),
    .out_of_range(out_of_range)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the configuration used by the color predictor.
  logic [2:0]            ramp_count;
  logic [RGBW-1:0]       ramp_oor_rgb;
  logic [CFG_DATA_W-1:0] ramp_point [6];

  logic signed [QW:0] pending_qualities [$];
  color_t             expected_colors [$];
  int  error_count = 0;
  int  watchdog = 0;
  int  sender_gap = 0;
  int  idle_enable = 1;
  bit  sender_hold = 0;
  bit  config_pending = 0;
  logic [CFG_IDX_W-1:0]  config_index_next;
  logic [CFG_DATA_W-1:0] config_data_next;

  function automatic int active_points();
    return (ramp_count > 6) ? 6 : ramp_count;
  endfunction

  // Color of a breakpoint at qv; the highest matching slot wins.
  function automatic bit lookup_point(input logic [QW-1:0] qv,
                                      output logic [RGBW-1:0] rgb);
    bit hit;
    hit = 0;
    rgb = '0;
    for (int k = 0; k < active_points(); k++) begin
      if (ramp_point[k][40:24] == qv) begin
        rgb = ramp_point[k][23:0];
        hit = 1;
      end
    end
    return hit;
  endfunction

  function automatic logic [RGBW-1:0] anchor_color(input logic [QW-1:0] qv);
    logic [RGBW-1:0] rgb;
    if (lookup_point(qv, rgb)) return rgb;
    return (qv == 0) ? BLACK : WHITE;
  endfunction

  function automatic logic [CW-1:0] blend_channel(input int c0, input int c1,
                                                  input int qa, input int qb,
                                                  input int q);
    longint span, acc;
    span = qb - qa;
    acc = (c0 * longint'(qb - q) + c1 * longint'(q - qa) + span / 2) / span;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  function automatic color_t ramp_color(input logic signed [QW:0] q_in);
    color_t c;
    logic [RGBW-1:0] rgb, c0, c1;
    int q, qa, qb, p;
    if (q_in < 0 || q_in > $signed({1'b0, QONE})) begin
      c = {ramp_oor_rgb, 1'b1};
      return c;
    end
    q = int'(q_in);
    if (lookup_point(q[QW-1:0], rgb)) begin
      c = {rgb, 1'b0};
    end else if (q == 0 || q == 65536) begin
      c = {anchor_color(q[QW-1:0]), 1'b0};
    end else begin
      qa = 0;
      qb = 65536;
      for (int k = 0; k < active_points(); k++) begin
        p = int'(ramp_point[k][40:24]);
        if (qa < p && p < q) qa = p;
        if (qb > p && p > q) qb = p;
      end
      c0 = anchor_color(qa[QW-1:0]);
      c1 = anchor_color(qb[QW-1:0]);
      c.red   = blend_channel(c0[23:16], c1[23:16], qa, qb, q);
      c.green = blend_channel(c0[15:8], c1[15:8], qa, qb, q);
      c.blue  = blend_channel(c0[7:0], c1[7:0], qa, qb, q);
      c.oor   = 1'b0;
    end
    return c;
  endfunction

  // Appends one quality to the sender's queue.
  task automatic queue_quality(input logic signed [QW:0] v);
    pending_qualities = {pending_qualities, v};
  endtask

  // Driver: takes the next quality from the queue, with random gaps, unless a
  // configuration phase holds the sender off.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_colors = {expected_colors, ramp_color(quality)};
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (sender_hold || pending_qualities.size() == 0) begin
        start <= 1'b0;
      end else if (sender_gap > 0) begin
        sender_gap <= sender_gap - 1;
        start <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        sender_gap <= $urandom_range(1, 16) - 1;
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        quality <= pending_qualities.pop_front();
      end
    end
  end

  // Configuration writes go out as single-cycle pulses from the stimulus.
  always @(posedge clk) begin
    if (config_pending) begin
      cfg_we <= 1'b1;
      cfg_index <= config_index_next;
      cfg_data <= config_data_next;
      config_pending <= 1'b0;
    end else begin
      cfg_we <= 1'b0;
    end
  end

  // Monitor: every done pulse is one color, checked against the oldest expectation.
  always @(posedge clk) begin
    color_t want;
    if (!rst && done) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected color r=%0d g=%0d b=%0d oor=%0b",
                 $time, red, green, blue, out_of_range);
        error_count++;
      end else begin
        want = expected_colors.pop_front();
        if (red !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, red);
          error_count++;
        end
        if (green !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, green);
          error_count++;
        end
        if (blue !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, blue);
          error_count++;
        end
        if (out_of_range !== want.oor) begin
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, want.oor, out_of_range);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no accepted item, no color and no configuration write.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    config_index_next = idx;
    config_data_next = val;
    config_pending = 1'b1;
    @(posedge clk);
    @(posedge clk);
    // Track the write the same way the block treats it.
    case (idx)
      REG_POINT_COUNT: ramp_count = val[2:0];
      REG_OOR_COLOR:   ramp_oor_rgb = val[23:0];
      default: if (idx - REG_POINT_BASE < 6) ramp_point[idx - REG_POINT_BASE] = val;
    endcase
  endtask

  // Lets the queue empty, then holds the sender until the pipeline has drained
  // so configuration may change.
  task automatic drain_pipeline();
    while (pending_qualities.size() != 0) @(posedge clk);
    sender_hold = 1;
    wait (!start);
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic release_sender();
    sender_hold = 0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] make_point(input int q,
                                                       input logic [23:0] rgb);
    logic [16:0] qq;
    qq = q[16:0];
    return {qq, rgb};
  endfunction

  // Random quality: mostly inside the ramp, often on or next to breakpoints, some out of range.
  function automatic logic signed [QW:0] random_quality();
    int sel;
    logic [QW:0] raw;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      raw = 18'($urandom);
    end else if (sel < 7 && active_points() > 0) begin
      raw = {1'b0, ramp_point[$urandom_range(0, active_points() - 1)][40:24]};
      raw = 18'(raw + $urandom_range(0, 2) - 1);
    end else if (sel == 7) begin
      raw = ($urandom_range(0, 1)) ? 18'd0 : {1'b0, QONE};
    end else begin
      raw = 18'($urandom_range(0, 65536));
    end
    return raw;
  endfunction

  task automatic random_setup(input bit extreme);
    int q;
    write_reg(REG_POINT_COUNT,
              CFG_DATA_W'(extreme ? 3'd7 : 3'($urandom_range(0, 7))));
    write_reg(REG_OOR_COLOR, CFG_DATA_W'({$urandom, $urandom}));
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 5))
        0: q = 0;
        1: q = 65536;
        2: q = $urandom_range(65537, 131071);
        default: q = $urandom_range(1, 65535);
      endcase
      write_reg(CFG_IDX_W'(REG_POINT_BASE + k),
                make_point(q, extreme ? 24'hFFFFFF : 24'($urandom)));
    end
  endtask

  initial begin
    ramp_count = 0;
    ramp_oor_rgb = OOR_RESET;
    for (int k = 0; k < 6; k++) ramp_point[k] = '0;
    sender_hold = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset configuration, implicit black and white ends only.
    queue_quality(18'sh20000);
    queue_quality(-18'sd1);
    queue_quality(18'sd0);
    queue_quality(18'sd1);
    queue_quality(18'sd32768);
    queue_quality(18'sd65535);
    queue_quality(18'sd65536);
    queue_quality(18'sd65537);
    queue_quality(18'sh1FFFF);
    release_sender();
    drain_pipeline();

    // Directed: duplicate qualities, a point beyond one, count of 7.
    write_reg(REG_OOR_COLOR, CFG_DATA_W'(24'h123456));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 0), make_point(16384, 24'hFF0000));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 1), make_point(16384, 24'h00FF00));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 2), make_point(70000, 24'h0000FF));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 3), make_point(0, 24'h808080));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 4), make_point(65536, 24'h010203));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 5), make_point(49152, 24'hFFFFFF));
    write_reg(CFG_IDX_W'(REG_POINT_BASE + 5), '1);
    write_reg(REG_POINT_COUNT, CFG_DATA_W'(3'd7));
    queue_quality(18'sd0);
    queue_quality(18'sd16384);
    queue_quality(18'sd8192);
    queue_quality(18'sd40000);
    queue_quality(18'sd49152);
    queue_quality(18'sd60000);
    queue_quality(18'sd65536);
    queue_quality(18'sd70000);
    queue_quality(18'sh20000);
    release_sender();
    drain_pipeline();
    // Slots above the count are ignored.
    write_reg(REG_POINT_COUNT, CFG_DATA_W'(3'd2));
    queue_quality(18'sd49152);
    queue_quality(18'sd0);
    queue_quality(18'sd65536);
    release_sender();
    drain_pipeline();

    // Random phases, each with a fresh setup and some extremes.
    for (int phase = 0; phase < 8; phase++) begin
      random_setup(phase == 0 || phase == 5);
      if (phase == 7) begin
        write_reg(REG_OOR_COLOR, '0);
        idle_enable = 0;
      end
      for (int i = 0; i < 100; i++) queue_quality(random_quality());
      release_sender();
      drain_pipeline();
    end

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
